FILE: src/slcww_pkg.sv
`default_nettype none

package slcww_pkg;

    localparam int FRAME_WIDTH_DEF  = 320;
    localparam int FRAME_HEIGHT_DEF = 240;

    // command codes
    localparam logic [7:0] CMD_NONE     = 8'h00;
    localparam logic [7:0] CMD_RESET    = 8'h01;
    localparam logic [7:0] CMD_READ_ID  = 8'h04;
    localparam logic [7:0] CMD_WAKE     = 8'h11;
    localparam logic [7:0] CMD_SHOW     = 8'h29;
    localparam logic [7:0] CMD_COLS     = 8'h2a;
    localparam logic [7:0] CMD_ROWS     = 8'h2b;
    localparam logic [7:0] CMD_MEMWRITE = 8'h2c;
    localparam logic [7:0] CMD_ACCESS   = 8'h36;
    localparam logic [7:0] CMD_FORMAT   = 8'h3a;

    localparam logic [7:0] FORMAT_565   = 8'h55;
    localparam logic [7:0] ID_LAST      = 8'he3;
    localparam logic [7:0] ID_FILL      = 8'h00;

    localparam logic [1:0] ID_IDX_LAST  = 2'd3;
    localparam logic [1:0] PARAM_LAST   = 2'd3;

    // reciprocal constants for the rounding divide by 31 and by 63
    localparam logic [13:0] RECIP_31 = 14'd8457;
    localparam logic [14:0] RECIP_63 = 15'd16645;

    typedef struct packed {
        logic       action;
        logic [7:0] spi_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       pixel_valid;
        logic [8:0] pixel_col;
        logic [7:0] pixel_row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_clear;
        logic       panel_on;
        logic       asleep;
        logic [7:0] orientation;
    } t_result;

    function automatic logic [7:0] id_byte(input logic [1:0] idx);
        logic [7:0] v;
        if (idx == ID_IDX_LAST) begin
            v = ID_LAST;
        end else begin
            v = ID_FILL;
        end
        return v;
    endfunction

    // (c*255 + 15) / 31 by multiply and shift, exact for 5-bit c
    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [12:0] x;
        logic [26:0] p;
        x = 13'({c, 8'h00} - {8'h00, c}) + 13'd15;
        p = 27'(x) * 27'(RECIP_31);
        return p[25:18];
    endfunction

    // (c*255 + 31) / 63 by multiply and shift, exact for 6-bit c
    function automatic logic [7:0] expand6(input logic [5:0] c);
        logic [13:0] x;
        logic [28:0] p;
        x = 14'({c, 8'h00} - {8'h00, c}) + 14'd31;
        p = 29'(x) * 29'(RECIP_63);
        return p[27:20];
    endfunction

endpackage

`default_nettype wire

FILE: src/spi_lcd_command_window_writer.sv
// a result word is registered and is valid in the cycle after its input word is accepted
// throughput: one word per cycle while the output is taken, set by the single result register
// o_in_ready stays high while the result register is empty or being taken
// reset: synchronous active-low i_rst_n returns all control state, windows,
// cursor and status to power-on values; nothing is pending afterwards
`default_nettype none

module spi_lcd_command_window_writer #(
    parameter int FRAME_WIDTH  = slcww_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = slcww_pkg::FRAME_HEIGHT_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire slcww_pkg::t_item i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output slcww_pkg::t_result  o_out_result
);
    import slcww_pkg::*;

    localparam logic [15:0] FW      = 16'(FRAME_WIDTH);
    localparam logic [15:0] FH      = 16'(FRAME_HEIGHT);
    localparam logic [15:0] COL_MAX = 16'(FRAME_WIDTH - 1);
    localparam logic [15:0] ROW_MAX = 16'(FRAME_HEIGHT - 1);

    logic [7:0]  r_active, n_active;
    logic [7:0]  r_format, n_format;
    logic [7:0]  r_access, n_access;
    logic [7:0]  r_param0, r_param1, r_param2;
    logic [7:0]  n_param0, n_param1, n_param2;
    logic [1:0]  r_param_count, n_param_count;
    logic [1:0]  r_id_index, n_id_index;
    logic [15:0] r_col_start, n_col_start, r_col_end, n_col_end;
    logic [15:0] r_row_start, n_row_start, r_row_end, n_row_end;
    logic [15:0] r_cur_col, n_cur_col, r_cur_row, n_cur_row;
    logic        r_high_held, n_high_held;
    logic [7:0]  r_high_byte, n_high_byte;
    logic        r_disp_on, n_disp_on;
    logic        r_sleeping, n_sleeping;

    logic        r_out_valid;
    t_result     r_result, n_result;

    logic        accept;
    logic [15:0] col_inc, row_inc;
    logic [15:0] ppair;
    logic [15:0] last_pair;

    assign o_in_ready   = !r_out_valid || i_out_ready;
    assign accept       = i_in_valid && o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_result;

    assign col_inc   = r_cur_col + 16'd1;
    assign row_inc   = r_cur_row + 16'd1;
    assign ppair     = {r_high_byte, i_in_item.spi_byte};
    assign last_pair = {r_param2, i_in_item.spi_byte};

    always_comb begin
        n_active      = r_active;
        n_format      = r_format;
        n_access      = r_access;
        n_param0      = r_param0;
        n_param1      = r_param1;
        n_param2      = r_param2;
        n_param_count = r_param_count;
        n_id_index    = r_id_index;
        n_col_start   = r_col_start;
        n_col_end     = r_col_end;
        n_row_start   = r_row_start;
        n_row_end     = r_row_end;
        n_cur_col     = r_cur_col;
        n_cur_row     = r_cur_row;
        n_high_held   = r_high_held;
        n_high_byte   = r_high_byte;
        n_disp_on     = r_disp_on;
        n_sleeping    = r_sleeping;
        n_result      = '0;

        // shifted-out byte depends on the command before this word
        if (r_active == CMD_READ_ID) begin
            n_result.read_byte = id_byte(r_id_index);
            n_id_index         = r_id_index + 2'd1;
        end

        if (!i_in_item.action) begin
            n_active      = i_in_item.spi_byte;
            n_param_count = '0;
            n_id_index    = '0;
            n_high_held   = 1'b0;
            case (i_in_item.spi_byte)
                CMD_RESET: begin
                    n_active             = CMD_NONE;
                    n_format             = FORMAT_565;
                    n_access             = '0;
                    n_col_start          = '0;
                    n_col_end            = COL_MAX;
                    n_row_start          = '0;
                    n_row_end            = ROW_MAX;
                    n_cur_col            = '0;
                    n_cur_row            = '0;
                    n_disp_on            = 1'b0;
                    n_sleeping           = 1'b1;
                    n_result.frame_clear = 1'b1;
                end
                CMD_WAKE:     n_sleeping = 1'b0;
                CMD_SHOW:     n_disp_on  = 1'b1;
                CMD_MEMWRITE: begin
                    n_cur_col = r_col_start;
                    n_cur_row = r_row_start;
                end
                default: ;
            endcase
        end else begin
            case (r_active)
                CMD_COLS, CMD_ROWS: begin
                    if (r_param_count != PARAM_LAST) begin
                        case (r_param_count)
                            2'd0:    n_param0 = i_in_item.spi_byte;
                            2'd1:    n_param1 = i_in_item.spi_byte;
                            default: n_param2 = i_in_item.spi_byte;
                        endcase
                        n_param_count = r_param_count + 2'd1;
                    end else begin
                        if (r_active == CMD_COLS) begin
                            n_col_start = {r_param0, r_param1};
                            n_col_end   = last_pair;
                        end else begin
                            n_row_start = {r_param0, r_param1};
                            n_row_end   = last_pair;
                        end
                        n_param_count = '0;
                    end
                end
                CMD_ACCESS: n_access = i_in_item.spi_byte;
                CMD_FORMAT: n_format = i_in_item.spi_byte;
                CMD_MEMWRITE: begin
                    if (r_format == FORMAT_565) begin
                        if (!r_high_held) begin
                            n_high_byte = i_in_item.spi_byte;
                            n_high_held = 1'b1;
                        end else begin
                            n_high_held = 1'b0;
                            if (r_cur_col < FW && r_cur_row < FH) begin
                                n_result.pixel_valid = 1'b1;
                                n_result.pixel_col   = r_cur_col[8:0];
                                n_result.pixel_row   = r_cur_row[7:0];
                                n_result.red         = expand5(ppair[15:11]);
                                n_result.green       = expand6(ppair[10:5]);
                                n_result.blue        = expand5(ppair[4:0]);
                            end
                            // cursor walks the window, wrapping at its edges
                            if (col_inc > r_col_end) begin
                                n_cur_col = r_col_start;
                                n_cur_row = (row_inc > r_row_end) ? r_row_start : row_inc;
                            end else begin
                                n_cur_col = col_inc;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        n_result.panel_on    = n_disp_on;
        n_result.asleep      = n_sleeping;
        n_result.orientation = n_access;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= CMD_NONE;
            r_format      <= FORMAT_565;
            r_access      <= '0;
            r_param_count <= '0;
            r_id_index    <= '0;
            r_col_start   <= '0;
            r_col_end     <= COL_MAX;
            r_row_start   <= '0;
            r_row_end     <= ROW_MAX;
            r_cur_col     <= '0;
            r_cur_row     <= '0;
            r_high_held   <= 1'b0;
            r_disp_on     <= 1'b0;
            r_sleeping    <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_active      <= n_active;
                r_format      <= n_format;
                r_access      <= n_access;
                r_param_count <= n_param_count;
                r_id_index    <= n_id_index;
                r_col_start   <= n_col_start;
                r_col_end     <= n_col_end;
                r_row_start   <= n_row_start;
                r_row_end     <= n_row_end;
                r_cur_col     <= n_cur_col;
                r_cur_row     <= n_cur_row;
                r_high_held   <= n_high_held;
                r_disp_on     <= n_disp_on;
                r_sleeping    <= n_sleeping;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_param0    <= n_param0;
            r_param1    <= n_param1;
            r_param2    <= n_param2;
            r_high_byte <= n_high_byte;
            r_result    <= n_result;
        end
    end

`ifndef SYNTHESIS
    a_clear_restores_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_result.frame_clear) |->
        (!o_out_result.panel_on && o_out_result.asleep && o_out_result.orientation == '0))
        else $error("frame clear word carries non-reset status");

    a_cmd_drops_half_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_in_item.action) |=> (!r_high_held && r_param_count == '0))
        else $error("command word left pixel or window bytes pending");

    a_high_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_item.action && r_active == CMD_MEMWRITE &&
         r_format == FORMAT_565 && !r_high_held) |=> (r_high_held && !o_out_result.pixel_valid))
        else $error("first pixel byte not held");

    a_id_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_active == CMD_READ_ID && r_id_index == ID_IDX_LAST) |=>
        (o_out_result.read_byte == ID_LAST))
        else $error("read id sequence out of step");
`endif

endmodule

`default_nettype wire
